[src/ctls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctls_pkg: shared types and constants of the token scanner
// Beat types of both channels, scanner modes, token class and error codes,
// and the keyword table.
// ----------------------------------------------------------------------------
package ctls_pkg;

  localparam int LEN_W    = 16;
  localparam int LINE_W   = 24;
  localparam int KW_COUNT = 11;
  localparam int KW_CHARS = 8;
  localparam int Q_DEPTH  = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        token_class;
    logic [31:0]       start_offset;
    logic [LEN_W-1:0]  token_length;
    logic [LINE_W-1:0] line_number;
    logic [3:0]        keyword_index;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic [1:0]        error_kind;
    logic              last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUMBER,
    M_STRING,
    M_OPER,
    M_LINECOM,
    M_BLOCKCOM,
    M_BLOCKSTAR
  } mode_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] TC_KEYWORD  = 3'd0;
  localparam logic [2:0] TC_IDENT    = 3'd1;
  localparam logic [2:0] TC_OPERATOR = 3'd2;
  localparam logic [2:0] TC_NUMBER   = 3'd3;
  localparam logic [2:0] TC_STRING   = 3'd4;
  localparam logic [2:0] TC_DELIM    = 3'd5;
  localparam logic [2:0] TC_ERROR    = 3'd6;

  localparam logic [1:0] EK_NONE   = 2'd0;
  localparam logic [1:0] EK_NUMBER = 2'd1;
  localparam logic [1:0] EK_STRING = 2'd2;
  localparam logic [1:0] EK_CHAR   = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;

  // Keyword spellings with the first character in the low byte, zero padded.
  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0074_6E69,  // int
    64'h0000_0074_616F_6C66,  // float
    64'h0000_676E_6972_7473,  // string
    64'h0000_0000_6469_6F76,  // void
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0072_6F66,  // for
    64'h0000_6E72_7574_6572,  // return
    64'h0000_006B_6165_7262,  // break
    64'h6575_6E69_746E_6F63   // continue
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd6, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_hit_t;

  function automatic kw_hit_t kw_lookup(input logic [LEN_W-1:0] len,
                                        input logic [KW_CHARS*8-1:0] text);
    kw_hit_t res;
    res = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (len == LEN_W'(KW_LEN[k]) && text == KW_TEXT[k]) begin
        res.hit = 1'b1;
        res.idx = 4'(k);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[src/ctls_scan_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctls_scan_core: scanner state and per-byte token logic
// Holds the scan state and, for the byte in the input register, works out
// the next state and up to two token records in one pass.
// ----------------------------------------------------------------------------
module ctls_scan_core #(
  parameter int KEYWORD_CHARS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_i,
  input  wire ctls_pkg::in_item_t item_i,
  output ctls_pkg::out_item_t     rec0_o,
  output ctls_pkg::out_item_t     rec1_o,
  output logic [1:0]              rec_vld_o
);

  localparam int LW = ctls_pkg::LEN_W;
  localparam int NW = ctls_pkg::LINE_W;
  localparam int IW = $clog2(KEYWORD_CHARS);

  ctls_pkg::mode_t                 mode_r, mode_nxt;
  logic [31:0]                     pos_r, pos_nxt;
  logic [NW-1:0]                   line_r, line_nxt;
  logic [31:0]                     tok_start_r, tok_start_nxt;
  logic [NW-1:0]                   tok_line_r, tok_line_nxt;
  logic [LW-1:0]                   tok_len_r, tok_len_nxt;
  logic [KEYWORD_CHARS-1:0][7:0]   prefix_r, prefix_nxt;
  logic [1:0]                      dot_r, dot_nxt;
  logic                            quote_r, quote_nxt;
  logic [7:0]                      held_r, held_nxt;

  logic [7:0]                      c;
  logic [NW-1:0]                   line_inc;
  logic [LW-1:0]                   len_inc;
  ctls_pkg::kw_hit_t               kw;
  ctls_pkg::out_item_t             blank, word_rec, num_rec, op1_rec, f_rec;
  ctls_pkg::mode_t                 f_mode;
  logic                            f_vld, use_fresh;
  logic                            is_space, is_alpha, is_digit, is_op, is_delim, is_pair;

  always_comb begin
    c        = item_i.char_code;
    is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    is_digit = (c >= "0" && c <= "9");
    is_op    = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
               (c == ">") || (c == "<") || (c == "!") || (c == "&") || (c == "|");
    is_delim = (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
               (c == ",") || (c == ";");
    if (c == "=") begin
      is_pair = (held_r == "=") || (held_r == "!") || (held_r == "<") || (held_r == ">") ||
                (held_r == "+") || (held_r == "-") || (held_r == "*") || (held_r == "/");
    end else begin
      is_pair = (held_r == "&" && c == "&") || (held_r == "|" && c == "|");
    end

    line_inc = (c == ctls_pkg::CH_LF && line_r != '1) ? line_r + 1'b1 : line_r;
    len_inc  = (tok_len_r != '1) ? tok_len_r + 1'b1 : tok_len_r;
    kw       = ctls_pkg::kw_lookup(tok_len_r, prefix_r[ctls_pkg::KW_CHARS-1:0]);

    blank              = '0;
    word_rec           = blank;
    word_rec.token_class   = kw.hit ? ctls_pkg::TC_KEYWORD : ctls_pkg::TC_IDENT;
    word_rec.start_offset  = tok_start_r;
    word_rec.token_length  = tok_len_r;
    word_rec.line_number   = tok_line_r;
    word_rec.keyword_index = kw.hit ? kw.idx : 4'd0;

    num_rec              = blank;
    num_rec.start_offset = tok_start_r;
    num_rec.token_length = tok_len_r;
    num_rec.line_number  = tok_line_r;
    if (dot_r > 2'd1) begin
      num_rec.token_class = ctls_pkg::TC_ERROR;
      num_rec.error_kind  = ctls_pkg::EK_NUMBER;
    end else begin
      num_rec.token_class = ctls_pkg::TC_NUMBER;
    end

    op1_rec              = blank;
    op1_rec.token_class  = ctls_pkg::TC_OPERATOR;
    op1_rec.start_offset = tok_start_r;
    op1_rec.token_length = LW'(1);
    op1_rec.line_number  = tok_line_r;
    op1_rec.first_byte   = held_r;

    f_rec              = blank;
    f_rec.start_offset = pos_r;
    f_rec.token_length = LW'(1);
    f_rec.line_number  = line_inc;
    f_rec.first_byte   = c;
    f_vld              = 1'b0;
    f_mode             = ctls_pkg::M_IDLE;
    priority if (is_space) begin
      f_mode = ctls_pkg::M_IDLE;
    end else if (is_alpha || c == "_") begin
      f_mode = ctls_pkg::M_WORD;
    end else if (is_digit) begin
      f_mode = ctls_pkg::M_NUMBER;
    end else if (c == "\"" || c == "'") begin
      f_mode = ctls_pkg::M_STRING;
    end else if (is_op) begin
      f_mode = ctls_pkg::M_OPER;
    end else if (is_delim) begin
      f_vld             = 1'b1;
      f_rec.token_class = ctls_pkg::TC_DELIM;
    end else begin
      f_vld             = 1'b1;
      f_rec.token_class = ctls_pkg::TC_ERROR;
      f_rec.error_kind  = ctls_pkg::EK_CHAR;
    end

    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    line_nxt      = line_r;
    tok_start_nxt = tok_start_r;
    tok_line_nxt  = tok_line_r;
    tok_len_nxt   = tok_len_r;
    prefix_nxt    = prefix_r;
    dot_nxt       = dot_r;
    quote_nxt     = quote_r;
    held_nxt      = held_r;
    rec0_o        = blank;
    rec1_o        = blank;
    rec_vld_o     = 2'b00;
    use_fresh     = 1'b0;

    if (item_i.kind == ctls_pkg::KIND_END) begin
      unique case (mode_r)
        ctls_pkg::M_WORD: begin
          rec0_o       = word_rec;
          rec_vld_o[0] = 1'b1;
        end
        ctls_pkg::M_NUMBER: begin
          rec0_o       = num_rec;
          rec_vld_o[0] = 1'b1;
        end
        ctls_pkg::M_STRING: begin
          rec0_o              = num_rec;
          rec0_o.token_class  = ctls_pkg::TC_ERROR;
          rec0_o.error_kind   = ctls_pkg::EK_STRING;
          rec_vld_o[0]        = 1'b1;
        end
        ctls_pkg::M_OPER: begin
          rec0_o       = op1_rec;
          rec_vld_o[0] = 1'b1;
        end
        default: begin
        end
      endcase
      mode_nxt      = ctls_pkg::M_IDLE;
      pos_nxt       = '0;
      line_nxt      = NW'(1);
      tok_start_nxt = '0;
      tok_line_nxt  = NW'(1);
      tok_len_nxt   = '0;
      prefix_nxt    = '0;
      dot_nxt       = '0;
      quote_nxt     = 1'b0;
      held_nxt      = '0;
    end else begin
      line_nxt = line_inc;
      pos_nxt  = pos_r + 32'd1;
      unique case (mode_r)
        ctls_pkg::M_WORD: begin
          if (is_alpha || is_digit || c == "_") begin
            if (tok_len_r < LW'(KEYWORD_CHARS)) begin
              prefix_nxt[tok_len_r[IW-1:0]] = c;
            end
            tok_len_nxt = len_inc;
          end else begin
            rec0_o       = word_rec;
            rec_vld_o[0] = 1'b1;
            use_fresh    = 1'b1;
          end
        end
        ctls_pkg::M_NUMBER: begin
          if (is_digit || c == ".") begin
            if (c == "." && dot_r < 2'd2) begin
              dot_nxt = dot_r + 2'd1;
            end
            tok_len_nxt = len_inc;
          end else begin
            rec0_o       = num_rec;
            rec_vld_o[0] = 1'b1;
            use_fresh    = 1'b1;
          end
        end
        ctls_pkg::M_STRING: begin
          tok_len_nxt = len_inc;
          if (c == (quote_r ? 8'(39) : 8'(34))) begin
            rec0_o              = num_rec;
            rec0_o.token_class  = ctls_pkg::TC_STRING;
            rec0_o.error_kind   = ctls_pkg::EK_NONE;
            rec0_o.token_length = len_inc;
            rec_vld_o[0]        = 1'b1;
            mode_nxt            = ctls_pkg::M_IDLE;
          end else if (c == ctls_pkg::CH_LF) begin
            rec0_o              = num_rec;
            rec0_o.token_class  = ctls_pkg::TC_ERROR;
            rec0_o.error_kind   = ctls_pkg::EK_STRING;
            rec0_o.token_length = len_inc;
            rec_vld_o[0]        = 1'b1;
            mode_nxt            = ctls_pkg::M_IDLE;
          end
        end
        ctls_pkg::M_OPER: begin
          priority if (held_r == "/" && c == "/") begin
            mode_nxt = ctls_pkg::M_LINECOM;
          end else if (held_r == "/" && c == "*") begin
            mode_nxt = ctls_pkg::M_BLOCKCOM;
          end else if (is_pair) begin
            rec0_o              = op1_rec;
            rec0_o.token_length = LW'(2);
            rec0_o.second_byte  = c;
            rec_vld_o[0]        = 1'b1;
            mode_nxt            = ctls_pkg::M_IDLE;
          end else begin
            rec0_o       = op1_rec;
            rec_vld_o[0] = 1'b1;
            use_fresh    = 1'b1;
          end
        end
        ctls_pkg::M_LINECOM: begin
          if (c == ctls_pkg::CH_LF) begin
            mode_nxt = ctls_pkg::M_IDLE;
          end
        end
        ctls_pkg::M_BLOCKCOM: begin
          if (c == "*") begin
            mode_nxt = ctls_pkg::M_BLOCKSTAR;
          end
        end
        ctls_pkg::M_BLOCKSTAR: begin
          if (c == "/") begin
            mode_nxt = ctls_pkg::M_IDLE;
          end else if (c != "*") begin
            mode_nxt = ctls_pkg::M_BLOCKCOM;
          end
        end
        default: begin
          use_fresh = 1'b1;
        end
      endcase
    end

    if (use_fresh) begin
      mode_nxt = f_mode;
      if (f_mode != ctls_pkg::M_IDLE) begin
        tok_start_nxt = pos_r;
        tok_line_nxt  = line_inc;
        tok_len_nxt   = LW'(1);
      end
      if (f_mode == ctls_pkg::M_WORD) begin
        prefix_nxt    = '0;
        prefix_nxt[0] = c;
      end
      if (f_mode == ctls_pkg::M_NUMBER) begin
        dot_nxt = '0;
      end
      if (f_mode == ctls_pkg::M_STRING) begin
        quote_nxt = (c == "'");
      end
      if (f_mode == ctls_pkg::M_OPER) begin
        held_nxt = c;
      end
      if (rec_vld_o[0]) begin
        rec1_o       = f_rec;
        rec_vld_o[1] = f_vld;
      end else begin
        rec0_o       = f_rec;
        rec_vld_o[0] = f_vld;
      end
    end

    rec0_o.last_of_run = !rec_vld_o[1];
    rec1_o.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctls_pkg::M_IDLE;
      pos_r  <= '0;
      line_r <= NW'(1);
    end else if (step_i) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i) begin
      tok_start_r <= tok_start_nxt;
      tok_line_r  <= tok_line_nxt;
      tok_len_r   <= tok_len_nxt;
      prefix_r    <= prefix_nxt;
      dot_r       <= dot_nxt;
      quote_r     <= quote_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule
`default_nettype wire

[src/ctls_rec_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ctls_rec_queue: result queue
// Small register queue that takes up to two token records a cycle and
// presents the oldest one on the result channel.
// ----------------------------------------------------------------------------
module ctls_rec_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          push_i,
  input  wire ctls_pkg::out_item_t rec0_i,
  input  wire ctls_pkg::out_item_t rec1_i,
  input  wire logic                pop_i,
  output ctls_pkg::out_item_t      head_o,
  output logic                     vld_o,
  output logic                     room_o
);

  localparam int D  = ctls_pkg::Q_DEPTH;
  localparam int AW = $clog2(D);

  ctls_pkg::out_item_t q_r [D];
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]       wr_ptr_p1;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + AW'(push_i[0]) + AW'(push_i[1]);
    rd_ptr_nxt = rd_ptr_r + AW'(pop_i);
    cnt_nxt    = cnt_r + (AW+1)'(push_i[0]) + (AW+1)'(push_i[1]) - (AW+1)'(pop_i);
    head_o     = q_r[rd_ptr_r];
    vld_o      = (cnt_r != '0);
    room_o     = (cnt_r <= (AW+1)'(D - 2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i[0]) begin
      q_r[wr_ptr_r] <= rec0_i;
    end
    if (push_i[1]) begin
      q_r[wr_ptr_p1] <= rec1_i;
    end
  end

endmodule
`default_nettype wire

[src/c_like_token_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c_like_token_scanner: streaming lexer for a small C-like language
// Input register, single-pass scan logic and a four-entry result queue.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while in_stall is low and one
// end-of-input beat to flush. Each token gives one result beat, queued when
// the completing byte leaves the input register. A byte that closes one token
// and is itself a delimiter or a bad character yields two result beats,
// which leave one per cycle unless stalled through a four-entry queue, so
// the result port sets the rate for such bytes. A byte is taken from the
// input register only while at least two queue entries are free.
module c_like_token_scanner #(
  parameter int KEYWORD_CHARS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ctls_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ctls_pkg::out_item_t     out_data
);

  ctls_pkg::in_item_t  item_r;
  logic                item_vld_r;
  logic                step_w, room_w, pop_w;
  logic [1:0]          rec_vld_w;
  ctls_pkg::out_item_t rec0_w, rec1_w;

  assign step_w   = item_vld_r && room_w;
  assign in_stall = item_vld_r && !room_w;
  assign pop_w    = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_vld_r <= 1'b1;
    end else if (step_w) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  ctls_scan_core #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step_w),
    .item_i    (item_r),
    .rec0_o    (rec0_w),
    .rec1_o    (rec1_w),
    .rec_vld_o (rec_vld_w)
  );

  ctls_rec_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (rec_vld_w & {2{step_w}}),
    .rec0_i (rec0_w),
    .rec1_i (rec1_w),
    .pop_i  (pop_w),
    .head_o (out_data),
    .vld_o  (out_valid),
    .room_o (room_w)
  );

  a_two_beats_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    step_w && rec_vld_w[1] |-> rec_vld_w[0] && !rec0_w.last_of_run && rec1_w.last_of_run)
    else $error("second record without a first one or with a wrong last flag");

  a_silent_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_w && (rec_vld_w == 2'b00) && !out_valid |=> !out_valid)
    else $error("result beat appeared without a record");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    step_w && rec_vld_w[0] && !rec_vld_w[1] |-> rec0_w.last_of_run)
    else $error("lone record not flagged as last");

endmodule
`default_nettype wire
